// File: sv/cmb_pkg.sv
// ----------------------------------------------------------------------------
// cmb_pkg
// Shared types and constants for the column motion blur block.
// ----------------------------------------------------------------------------
package cmb_pkg;

    localparam int CH_W   = 8;            // bits per color channel
    localparam int NUM_CH = 3;            // red, green, blue
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int AMT_W  = 5;            // blur_amount register width
    localparam int CMP_W  = 7;            // common width for count compares

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIVGO,
        ST_DIVW,
        ST_OUT
    } t_state;

endpackage

// File: sv/cmb_ram.sv
// ----------------------------------------------------------------------------
// cmb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cmb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cmb_div.sv
// ----------------------------------------------------------------------------
// cmb_div
// Restoring divider, one quotient bit per cycle, three channel lanes sharing
// one bit counter and one divisor.
// ----------------------------------------------------------------------------
module cmb_div #(
    parameter int SUM_W = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [cmb_pkg::AMT_W-1:0]             i_divisor,
    input  logic [cmb_pkg::NUM_CH-1:0][SUM_W-1:0] i_dividend,
    output logic                                  o_done,
    output logic [cmb_pkg::NUM_CH-1:0][SUM_W-1:0] o_quot
);
    import cmb_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [NUM_CH-1:0][SUM_W-1:0] r_quot;
    logic [NUM_CH-1:0][AMT_W-1:0] r_rem;
    logic [NUM_CH-1:0][SUM_W-1:0] n_quot;
    logic [NUM_CH-1:0][AMT_W-1:0] n_rem;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;

    // one restoring step per lane
    always_comb begin
        logic [AMT_W:0] sh;
        for (int c = 0; c < NUM_CH; c++) begin
            sh = {r_rem[c], r_quot[c][SUM_W-1]};
            if (sh >= {1'b0, i_divisor}) begin
                n_rem[c]  = AMT_W'(sh - {1'b0, i_divisor});
                n_quot[c] = {r_quot[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c]  = sh[AMT_W-1:0];
                n_quot[c] = {r_quot[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: sv/column_motion_blur.sv
// ----------------------------------------------------------------------------
// column_motion_blur
// Horizontal motion blur over RGB pixels: blends each pixel with the mean of
// the blur_amount pixels before it on the same line.
// ----------------------------------------------------------------------------
// Sequence: a pass-through pixel (short history) goes through ST_OUT into the
//   output register; a blurred pixel runs amt history reads, the sum of the
//   last word, the divider start, 8+log2(MAX_BLUR) divider steps, the done
//   strobe and the output write, in that order.
// Throughput: one pixel at a time; the next beat is taken the cycle after the
//   result has moved into the output register; a stalled output holds the
//   result back in ST_OUT.
// Reset: synchronous, active low; clears sequencer, counters, output valid
//   and sets blur_amount to 1. History RAM is not cleared.
// ----------------------------------------------------------------------------
module column_motion_blur #(
    parameter int MAX_BLUR = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_wr_en,
    input  logic [cmb_pkg::AMT_W-1:0] i_cfg_wr_data,   // blur_amount
    // pixel input stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [23:0]               i_s_tdata,       // red_in, green_in, blue_in
    input  logic                      i_s_tuser,       // line_start
    // pixel output stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [23:0]               o_m_tdata        // red_out, green_out, blue_out
);
    import cmb_pkg::*;

    localparam int AW    = (MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 1;
    localparam int PW    = $clog2(MAX_BLUR + 1);           // pixels_seen width
    localparam int SUM_W = 8 + ((MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 0);
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_BLUR);
    localparam logic [AW-1:0]    LAST_A = AW'(MAX_BLUR - 1);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state                       r_state, n_state;
    logic [AMT_W-1:0]             r_cfg_amt;      // register as written
    logic [AMT_W-1:0]             r_amt;          // clamped amount for this beat
    logic [PW-1:0]                r_seen;         // earlier pixels on this line
    logic [AW-1:0]                r_hpos;         // next history write slot
    logic [AW-1:0]                r_rptr;         // history read pointer
    logic [AMT_W-1:0]             r_rcnt;         // reads issued
    logic                         r_rd_v;         // RAM data valid this cycle
    logic                         r_blur;         // beat takes the blur path
    logic [PIX_W-1:0]             r_pix;          // current pixel
    logic [NUM_CH-1:0][SUM_W-1:0] r_sum;          // window sums
    logic                         r_m_valid;
    logic [PIX_W-1:0]             r_m_data;

    // ------------------------------------------------------------------
    // clamped amount: zero acts as one, above MAX_BLUR acts as MAX_BLUR
    // ------------------------------------------------------------------
    logic [AMT_W-1:0] amt_eff;
    always_comb begin
        if (r_cfg_amt == '0) begin
            amt_eff = AMT_W'(1);
        end else if (CMP_W'(r_cfg_amt) > MAX_C) begin
            amt_eff = AMT_W'(MAX_BLUR);
        end else begin
            amt_eff = r_cfg_amt;
        end
    end

    logic          s_accept;
    logic [PW-1:0] seen_eff;
    logic          out_free;
    assign s_accept = i_s_tvalid && o_s_tready;
    assign seen_eff = i_s_tuser ? '0 : r_seen;
    assign out_free = !r_m_valid || i_m_tready;

    // ------------------------------------------------------------------
    // history RAM and divider
    // ------------------------------------------------------------------
    logic                         ram_we;
    logic                         rd_issue;
    logic [PIX_W-1:0]             ram_rdata;
    logic                         div_start;
    logic                         div_done;
    logic [NUM_CH-1:0][SUM_W-1:0] div_quot;

    cmb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_BLUR),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_hpos),
        .i_wdata (r_pix),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    cmb_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (r_amt),
        .i_dividend (r_sum),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ------------------------------------------------------------------
    // sequencer: next state and strobes
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        rd_issue   = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    // enough history on this line -> blur, else pass through
                    if (CMP_W'(seen_eff) >= CMP_W'(amt_eff)) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_READ: begin
                if (r_rcnt != r_amt) begin
                    rd_issue = 1'b1;
                end else begin
                    // last read word is summed this cycle
                    n_state = ST_DIVGO;
                end
            end
            ST_DIVGO: begin
                div_start = 1'b1;
                n_state   = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    ram_we  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_amt <= AMT_W'(1);
            r_seen    <= '0;
            r_hpos    <= '0;
            r_rcnt    <= '0;
            r_rd_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_amt <= i_cfg_wr_data;
            end
            r_rd_v <= rd_issue;
            if (s_accept) begin
                r_rcnt <= '0;
                if (CMP_W'(seen_eff) < MAX_C) begin
                    r_seen <= seen_eff + 1'b1;
                end else begin
                    r_seen <= seen_eff;
                end
            end else if (rd_issue) begin
                r_rcnt <= r_rcnt + 1'b1;
            end
            if (ram_we) begin
                r_hpos <= (r_hpos == LAST_A) ? '0 : r_hpos + 1'b1;
            end
            if (ram_we) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_pix  <= i_s_tdata;
            r_amt  <= amt_eff;
            r_blur <= CMP_W'(seen_eff) >= CMP_W'(amt_eff);
            r_sum  <= '0;
            // newest earlier pixel sits just behind the write slot
            r_rptr <= (r_hpos == '0) ? LAST_A : r_hpos - 1'b1;
        end else begin
            if (rd_issue) begin
                r_rptr <= (r_rptr == '0) ? LAST_A : r_rptr - 1'b1;
            end
            if (r_rd_v) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(ram_rdata[c*CH_W +: CH_W]);
                end
            end
        end
    end

    // blend: (cur + avg) >> 1 per channel
    logic [PIX_W-1:0] blend_pix;
    always_comb begin
        logic [CH_W:0] s9;
        for (int c = 0; c < NUM_CH; c++) begin
            s9 = {1'b0, r_pix[c*CH_W +: CH_W]} + {1'b0, div_quot[c][CH_W-1:0]};
            blend_pix[c*CH_W +: CH_W] = s9[CH_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_m_data <= r_blur ? blend_pix : r_pix;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// File: sv/cmb_checker.sv
// ----------------------------------------------------------------------------
// cmb_checker
// Port-level checks for column_motion_blur, bound to the top level.
// ----------------------------------------------------------------------------
module cmb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // stalled result beat holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result beat changed while stalled");

    // one pixel at a time: input closes right after a beat is taken
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a pixel is in work");

    // no result appears the cycle right after an input beat
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !$rose(o_m_tvalid))
        else $error("result appeared too early");

    // reset drops output valid
    a_reset_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind column_motion_blur cmb_checker u_cmb_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb - column_motion_blur testbench
// Drives RGB pixel beats through the blur block and checks every output beat
// against a value from the directed table or an in-bench predictor. A directed
// table comes first, covering reset, channel extremes, amount zero and the full
// 16-pixel window. Random lines at several blur amounts follow, under three
// stall mixes, two long output stalls and one full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cmb_pkg::*;

    localparam int HIST_DEPTH  = 16;   // matches the block's MAX_BLUR
    localparam int DIR_ROWS    = 26;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_BEATS = 67;
    localparam int TAIL_CYC    = 40;
    localparam int HOLD_CYC    = 400;

    // tdata layout, lowest bits first: red, green, blue
    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_rgb;

    typedef enum logic {ROW_PIX, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [AMT_W-1:0] amt;      // ROW_CFG only
        logic [23:0]      pix;      // 24'hRRGGBB
        bit               ls;
        bit               typed;    // 1: want is given, else predicted
        logic [23:0]      want;     // 24'hRRGGBB
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [AMT_W-1:0] i_cfg_wr_data = '0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [23:0]      i_s_tdata = '0;
    logic             i_s_tuser = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [23:0]      o_m_tdata;

    // predictor state
    t_rgb             hist_m [HIST_DEPTH];
    logic [3:0]       hist_wr_m = '0;
    int               seen_m = 0;
    logic [AMT_W-1:0] blur_amt_m = 5'd1;

    t_rgb blur_exp_q [$];
    int   errors = 0;
    int   pixels_in = 0;
    int   results_ok = 0;
    int   cfg_writes = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cnt = 0;

    // reset, extremes, amount zero, then a full 16-deep window
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_PIX, 5'd0,  24'h000000, 1'b0, 1'b1, 24'h000000}, // no line start yet
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b0, 1'b1, 24'h7f7f7f},
        '{ROW_PIX, 5'd0,  24'h000000, 1'b1, 1'b1, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hff00ff, 1'b0, 1'b1, 24'h7f007f},
        '{ROW_PIX, 5'd0,  24'h00ff00, 1'b0, 1'b1, 24'h7f7f7f},
        '{ROW_CFG, 5'd0,  24'h000000, 1'b0, 1'b0, 24'h000000}, // zero acts as one
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b1, 1'b1, 24'hffffff},
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b0, 1'b1, 24'hffffff},
        '{ROW_CFG, 5'd16, 24'h000000, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'h123456, 1'b1, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'h000000, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'ha55a3c, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hff0080, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'h01fe7f, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hfefefe, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'h808080, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'h00ffff, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hffff00, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'h7f8001, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hc0ffee, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'h00ff00, 1'b0, 1'b0, 24'h000000},
        '{ROW_PIX, 5'd0,  24'hffffff, 1'b0, 1'b0, 24'h000000}  // first blurred
    };

    // extremes first in the list, then amounts in between, zero and past the top
    logic [AMT_W-1:0] phase_amt [NUM_PHASES] = '{
        5'd16, 5'd1, 5'd7, 5'd31, 5'd0, 5'd4, 5'd17, 5'd10, 5'd16
    };

    column_motion_blur dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),      // red_in, green_in, blue_in
        .i_s_tuser     (i_s_tuser),      // line_start
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)       // red_out, green_out, blue_out
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Blend of each channel with the mean of the previous amt pixels on the
    // line; short history passes the pixel through. Updates the ring buffer.
    function automatic t_rgb predict_blur(t_rgb px, bit ls);
        int         amt;
        int         sum_r, sum_g, sum_b;
        logic [3:0] idx;
        t_rgb       res;
        amt = int'(blur_amt_m);
        if (amt == 0)
            amt = 1;
        if (amt > HIST_DEPTH)
            amt = HIST_DEPTH;
        if (ls)
            seen_m = 0;
        res = px;
        if (seen_m >= amt) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int k = 1; k <= amt; k++) begin
                idx = hist_wr_m - 4'(k);
                sum_r += int'(hist_m[idx].r);
                sum_g += int'(hist_m[idx].g);
                sum_b += int'(hist_m[idx].b);
            end
            res.r = 8'((int'(px.r) + sum_r / amt) >> 1);
            res.g = 8'((int'(px.g) + sum_g / amt) >> 1);
            res.b = 8'((int'(px.b) + sum_b / amt) >> 1);
        end
        hist_m[hist_wr_m] = px;
        hist_wr_m = hist_wr_m + 4'd1;
        if (seen_m < HIST_DEPTH)
            seen_m++;
        return res;
    endfunction

    function automatic t_rgb hex_to_rgb(logic [23:0] h);
        t_rgb p;
        p.r = h[23:16];
        p.g = h[15:8];
        p.b = h[7:0];
        return p;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Called just after a falling edge; returns just after a falling edge
    // with tvalid still high, so back-to-back beats stay back to back.
    task automatic send_pixel(t_rgb px, bit ls, bit typed, t_rgb want);
        t_rgb pred;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            do
                @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tdata  = px;
        i_s_tuser  = ls;
        i_s_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        pred = predict_blur(px, ls);
        blur_exp_q.push_back(typed ? want : pred);
        pixels_in++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (blur_exp_q.size() != 0)
            @(negedge i_clk);
    endtask

    // only while idle: all expected beats have come back
    task automatic write_blur_amount(logic [AMT_W-1:0] amt);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = amt;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        blur_amt_m    = amt;
        cfg_writes++;
    endtask

    // output side: random stalls, plus a long hold when hold_cnt is loaded
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            i_m_tready = 1'b0;
            hold_cnt   = hold_cnt - 1;
        end else begin
            i_m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // output checker
    t_rgb got_pix, want_pix;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_pix = o_m_tdata;
            if (blur_exp_q.size() == 0) begin
                report_mismatch("unexpected beat", int'(o_m_tdata), 0);
            end else begin
                want_pix = blur_exp_q.pop_front();
                if (got_pix.r !== want_pix.r)
                    report_mismatch("red_out", int'(got_pix.r), int'(want_pix.r));
                if (got_pix.g !== want_pix.g)
                    report_mismatch("green_out", int'(got_pix.g), int'(want_pix.g));
                if (got_pix.b !== want_pix.b)
                    report_mismatch("blue_out", int'(got_pix.b), int'(want_pix.b));
                results_ok++;
            end
        end
    end

    initial begin
        int   n, line_len;
        bit   ls;
        t_rgb px;
        for (int k = 0; k < HIST_DEPTH; k++)
            hist_m[k] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, no stalls on either side
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_blur_amount(dir_rows[i].amt);
            else
                send_pixel(hex_to_rgb(dir_rows[i].pix), dir_rows[i].ls,
                           dir_rows[i].typed, hex_to_rgb(dir_rows[i].want));
        end

        // random lines; stall mix rotates every three phases
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_blur_amount(phase_amt[ph]);
            case (ph / 3)
                0: begin send_idle_pct = 23; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 1 || ph == 7)
                hold_cnt = HOLD_CYC;   // sender keeps offering, input backs up
            n = 0;
            while (n < PHASE_BEATS) begin
                // mostly lines long enough to fill the window, a few short ones
                line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4)
                                                       : $urandom_range(8, 40);
                for (int k = 0; k < line_len && n < PHASE_BEATS; k++) begin
                    px.r = rand_chan();
                    px.g = rand_chan();
                    px.b = rand_chan();
                    // occasional stray line start breaks a line early
                    ls = (k == 0) || ($urandom_range(0, 39) == 0);
                    send_pixel(px, ls, 1'b0, '0);
                    n++;
                    if (ph == 4 && n == PHASE_BEATS / 2)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYC) @(negedge i_clk);
        if (blur_exp_q.size() != 0)
            report_mismatch("beats missing", 0, blur_exp_q.size());

        $display("tb: %0d pixels in, %0d results checked, %0d amount writes (0..31)",
                 pixels_in, results_ok, cfg_writes);
        $display("tb: covered short lines, full windows, long output stall, drain pause");
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
